/* src/pds_pkg.sv */
`default_nettype none

package pds_pkg;

   // One request word: the reference and the wanted output frequency.
   typedef struct packed {
      logic [31:0] input_freq_hz;
      logic [31:0] target_freq_hz;
   } pds_req_type;

   // One result word: the first divider set that meets every limit, or all zero when none does.
   typedef struct packed {
      logic       found;
      logic [7:0] feedback_div;
      logic [3:0] pre_div;
      logic [2:0] post_div_one;
      logic [2:0] post_div_two;
   } pds_rsp_type;

   localparam logic [31:0] FIN_MIN = 32'd5000000;
   localparam logic [31:0] FIN_MAX = 32'd64000000;
   localparam logic [7:0]  FBD_MIN = 8'd16;
   localparam logic [7:0]  FBD_MAX = 8'd200;
   localparam logic [31:0] VCO_MIN = 32'd500000000;
   localparam logic [31:0] VCO_MAX = 32'd2000000000;

   // Quotient bits produced by the feedback division, plus one overflow step.
   localparam int FBD_BITS = 8;

endpackage

`default_nettype wire

/* src/pds_sub.sv */
`default_nettype none

// Shared compare-and-subtract unit: one restoring division step.
module pds_sub #(
   parameter int W = 42
) (
   input  wire logic [W-1:0] rem,
   input  wire logic [W-1:0] val,
   output logic              ge,
   output logic [W-1:0]      diff
);

   assign ge   = (rem >= val);
   assign diff = rem - val;

endmodule

`default_nettype wire

/* src/pds_mul.sv */
`default_nettype none

// Shared multiplier, 32 bits by a narrow operand; the caller registers the product.
module pds_mul #(
   parameter int M_W = 10
) (
   input  wire logic [31:0]     a,
   input  wire logic [M_W-1:0]  b,
   output logic [31+M_W:0]      p
);

   assign p = {{M_W{1'b0}}, a} * {32'b0, b};

endmodule

`default_nettype wire

/* src/pll_divider_search.sv */
`default_nettype none

// Channel   Ports                       Handshake
// request   start, busy, req_data       taken when start is high and busy is low
// response  rsp_valid, rsp_data         shown for one cycle, cannot be held off
//
// Each prescaler costs a bit-serial division of all 32 input bits for the prescaled input
// and a range check. Each post divider pair (p1 >= p2 only) then costs three multiplies,
// up to nine division steps, one multiply and one check, all on one shared multiplier
// and one shared compare-and-subtract unit. The search stops at the first match.
// Reset returns the sequencer to idle; busy falls in the cycle the result word is shown,
// and the receiver cannot stall it.
module pll_divider_search #(
   parameter int MAX_PRE  = 8,
   parameter int MAX_POST = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire pds_pkg::pds_req_type  req_data,
   output logic                       rsp_valid,
   output pds_pkg::pds_rsp_type       rsp_data
);

   import pds_pkg::*;

   localparam int PRE_W  = $clog2(MAX_PRE + 1);
   localparam int POST_W = $clog2(MAX_POST + 1);
   localparam int MW_RAW = PRE_W + 2 * POST_W;
   localparam int M_W    = (MW_RAW > FBD_BITS) ? MW_RAW : FBD_BITS;
   localparam int W      = 32 + M_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIN_DIV,
      S_FIN_CHK,
      S_MUL_POST,
      S_MUL_M,
      S_MUL_N,
      S_FBD_DIV,
      S_MUL_VCO,
      S_CHECK
   } state_type;

   state_type         state_ff, state_in;
   pds_req_type       req_ff, req_in;
   logic [PRE_W-1:0]  pre_ff, pre_in;
   logic [POST_W-1:0] p1_ff, p1_in;
   logic [POST_W-1:0] p2_ff, p2_in;
   logic [W-1:0]      rem_ff, rem_in;
   logic [W-1:0]      dsr_ff, dsr_in;
   logic [W-1:0]      prod_ff, prod_in;
   logic [31:0]       quo_ff, quo_in;
   logic [31:0]       fin_ff, fin_in;
   logic [7:0]        fbd_ff, fbd_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   pds_rsp_type       rsp_ff, rsp_in;

   logic [W-1:0]      sub_rem, sub_val, sub_diff;
   logic              sub_ge;
   logic [31:0]       mul_a;
   logic [M_W-1:0]    mul_b;
   logic [W-1:0]      mul_p;
   logic [W-1:0]      step_rem;

   pds_sub #(.W(W)) u_sub (
      .rem  (sub_rem),
      .val  (sub_val),
      .ge   (sub_ge),
      .diff (sub_diff)
   );

   pds_mul #(.M_W(M_W)) u_mul (
      .a (mul_a),
      .b (mul_b),
      .p (mul_p)
   );

   always_comb begin
      if (state_ff == S_FIN_DIV) begin
         sub_rem = {rem_ff[W-2:0], req_ff.input_freq_hz[cnt_ff]};
         sub_val = W'(pre_ff);
      end else begin
         sub_rem = rem_ff;
         sub_val = dsr_ff;
      end
      step_rem = sub_ge ? sub_diff : sub_rem;
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MUL_POST: begin
            mul_a = 32'(p1_ff);
            mul_b = M_W'(p2_ff);
         end
         S_MUL_M: begin
            mul_a = prod_ff[31:0];
            mul_b = M_W'(pre_ff);
         end
         S_MUL_N: begin
            mul_a = req_ff.target_freq_hz;
            mul_b = prod_ff[M_W-1:0];
         end
         S_MUL_VCO: begin
            mul_a = fin_ff;
            mul_b = M_W'(fbd_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      logic to_next, to_pre;

      state_in     = state_ff;
      req_in       = req_ff;
      pre_in       = pre_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      fin_in       = fin_ff;
      fbd_in       = fbd_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      to_next      = 1'b0;
      to_pre       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               pre_in   = PRE_W'(1);
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = 5'd31;
               state_in = S_FIN_DIV;
            end
         end
         S_FIN_DIV: begin
            rem_in = step_rem;
            quo_in = {quo_ff[30:0], sub_ge};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = S_FIN_CHK;
            end
         end
         S_FIN_CHK: begin
            fin_in = quo_ff;
            p1_in  = POST_W'(1);
            p2_in  = POST_W'(1);
            if (quo_ff >= FIN_MIN && quo_ff <= FIN_MAX) begin
               state_in = S_MUL_POST;
            end else begin
               to_pre = 1'b1;
            end
         end
         S_MUL_POST: begin
            prod_in  = mul_p;
            state_in = S_MUL_M;
         end
         S_MUL_M: begin
            prod_in  = mul_p;
            state_in = S_MUL_N;
         end
         S_MUL_N: begin
            // Divisor starts at the reference shifted past the widest legal quotient.
            rem_in   = mul_p;
            dsr_in   = W'({req_ff.input_freq_hz, 8'b0});
            quo_in   = '0;
            cnt_in   = 5'(FBD_BITS);
            state_in = S_FBD_DIV;
         end
         S_FBD_DIV: begin
            rem_in = step_rem;
            dsr_in = dsr_ff >> 1;
            quo_in = {quo_ff[30:0], sub_ge};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'(FBD_BITS) && sub_ge) begin
               // Quotient of 256 or more cannot be a legal feedback divider.
               to_next = 1'b1;
            end else if (cnt_ff == 5'd0) begin
               fbd_in   = quo_in[7:0];
               state_in = S_MUL_VCO;
            end
         end
         S_MUL_VCO: begin
            prod_in  = mul_p;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // The output limit equals the VCO maximum and the post divide is at
            // least one, so the VCO check covers it.
            if (fbd_ff >= FBD_MIN && fbd_ff <= FBD_MAX &&
                prod_ff >= W'(VCO_MIN) && prod_ff <= W'(VCO_MAX)) begin
               rsp_valid_in         = 1'b1;
               rsp_in.found         = 1'b1;
               rsp_in.feedback_div  = fbd_ff;
               rsp_in.pre_div       = 4'(pre_ff);
               rsp_in.post_div_one  = 3'(p1_ff);
               rsp_in.post_div_two  = 3'(p2_ff);
               state_in             = S_IDLE;
            end else begin
               to_next = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Pairs with p1 below p2 are never visited: p1 restarts at p2.
      if (to_next) begin
         if (p1_ff < POST_W'(MAX_POST)) begin
            p1_in    = p1_ff + POST_W'(1);
            state_in = S_MUL_POST;
         end else if (p2_ff < POST_W'(MAX_POST)) begin
            p2_in    = p2_ff + POST_W'(1);
            p1_in    = p2_ff + POST_W'(1);
            state_in = S_MUL_POST;
         end else begin
            to_pre = 1'b1;
         end
      end

      if (to_pre) begin
         if (pre_ff < PRE_W'(MAX_PRE)) begin
            pre_in   = pre_ff + PRE_W'(1);
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = 5'd31;
            state_in = S_FIN_DIV;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            state_in     = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      pre_ff  <= pre_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      fin_ff  <= fin_in;
      fbd_ff  <= fbd_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
